FILE: src/tc8cmp_pkg.sv
// Shared types and constants for the 8-bit timer/counter with compare outputs.
package tc8cmp_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] cycle_count;
    } tc8cmp_in_t;

    // Result transaction payload
    typedef struct packed {
        logic [7:0] count_value;
        logic [2:0] flag_bits;
        logic       pin_a_level;
        logic       pin_b_level;
        logic       irq_overflow;
        logic       irq_match_a;
        logic       irq_match_b;
    } tc8cmp_out_t;

    // Opcodes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_FORCE_A = 2'd1;
    localparam logic [1:0] OP_FORCE_B = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CLOCK_SELECT = 3'd0;
    localparam logic [2:0] REG_WAVE_MODE    = 3'd1;
    localparam logic [2:0] REG_OUT_MODE_A   = 3'd2;
    localparam logic [2:0] REG_OUT_MODE_B   = 3'd3;
    localparam logic [2:0] REG_COMPARE_A    = 3'd4;
    localparam logic [2:0] REG_COMPARE_B    = 3'd5;
    localparam logic [2:0] REG_IRQ_MASK     = 3'd6;
    localparam logic [2:0] REG_PIN_OE       = 3'd7;

    // Waveform modes that run the counter
    localparam logic [2:0] WM_NORMAL = 3'd0;
    localparam logic [2:0] WM_CTC    = 3'd2;

    // Compare output actions
    localparam logic [1:0] OM_NONE   = 2'd0;
    localparam logic [1:0] OM_TOGGLE = 2'd1;
    localparam logic [1:0] OM_CLEAR  = 2'd2;
    localparam logic [1:0] OM_SET    = 2'd3;

    // Flag bit positions
    localparam int FLAG_OVF = 0;
    localparam int FLAG_A   = 1;
    localparam int FLAG_B   = 2;

    localparam int PRESCALE_W = 11;

    // Prescaler divisor for a clock select code; zero means stopped
    function automatic logic [PRESCALE_W-1:0] divisor_of(input logic [2:0] sel);
        logic [PRESCALE_W-1:0] d;
        begin
            case (sel)
                3'd1:    d = 11'd1;
                3'd2:    d = 11'd8;
                3'd3:    d = 11'd64;
                3'd4:    d = 11'd256;
                3'd5:    d = 11'd1024;
                default: d = 11'd0;
            endcase
            return d;
        end
    endfunction

endpackage

FILE: src/timer_counter_8bit_compare_core.sv
// 8-bit timer/counter with prescaler, normal/CTC modes and two compare outputs.
//
// Channels: in_valid/in_ready carry one transaction (opcode, cycle_count);
// out_valid/out_ready return one result transaction per input transaction;
// cfg_valid/cfg_ready/cfg_index/cfg_data write the configuration registers
// (cfg_ready is always high; write only while the block is idle).
// An advance transaction is handled one CPU cycle per clock
// by a single increment/compare unit: it is accepted in the idle state,
// runs its cycles in the run state and leaves through the finish state.
// Forces, the unused opcode, a stopped clock and cycle_count = 0 go straight from
// idle to finish. in_ready is high only while the sequencer is idle.
// The result sits in an output register; if the receiver stalls, the
// finished transaction waits in the finish state until the register frees,
// and no new input is taken meanwhile.
// Reset clears the control and state registers (not the result payload register),
// counter, prescaler, flags and pin levels to zero; in_ready is high from reset on.
module timer_counter_8bit_compare_core
    import tc8cmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tc8cmp_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output tc8cmp_out_t out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Configuration registers
    logic [2:0] clock_select_reg, clock_select_next;
    logic [2:0] wave_mode_reg, wave_mode_next;
    logic [1:0] out_mode_a_reg, out_mode_a_next;
    logic [1:0] out_mode_b_reg, out_mode_b_next;
    logic [7:0] compare_a_reg, compare_a_next;
    logic [7:0] compare_b_reg, compare_b_next;
    logic [2:0] irq_mask_reg, irq_mask_next;
    logic [1:0] pin_oe_reg, pin_oe_next;

    // Timer state
    logic [PRESCALE_W-1:0] prescale_left_reg, prescale_left_next;
    logic [7:0] counter_reg, counter_next;
    logic [2:0] flags_reg, flags_next;
    logic       out_a_reg, out_a_next;
    logic       out_b_reg, out_b_next;

    // Sequencer
    logic [1:0] state_reg, state_next;
    logic [7:0] cyc_left_reg, cyc_left_next;
    logic [2:0] irq_reg, irq_next;
    logic       out_valid_reg, out_valid_next;
    tc8cmp_out_t out_data_reg, out_data_next;

    // Shared tick unit
    logic [PRESCALE_W-1:0] divisor;
    logic                  mode_ok;
    logic [7:0]            tick_inc;
    logic [2:0]            tick_raise;

    function automatic logic apply_action(input logic level, input logic [1:0] mode,
                                          input logic enabled);
        logic r;
        begin
            r = level;
            if (enabled) begin
                case (mode)
                    OM_TOGGLE: r = ~level;
                    OM_CLEAR:  r = 1'b0;
                    OM_SET:    r = 1'b1;
                    default:   r = level;
                endcase
            end
            return r;
        end
    endfunction

    assign divisor   = divisor_of(clock_select_reg);
    assign mode_ok   = wave_mode_reg inside {WM_NORMAL, WM_CTC};
    assign tick_inc  = counter_reg + 8'd1;
    assign tick_raise = {tick_inc == compare_b_reg, tick_inc == compare_a_reg,
                         tick_inc == 8'd0};

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and tick datapath
    always_comb
    begin
        clock_select_next  = clock_select_reg;
        wave_mode_next     = wave_mode_reg;
        out_mode_a_next    = out_mode_a_reg;
        out_mode_b_next    = out_mode_b_reg;
        compare_a_next     = compare_a_reg;
        compare_b_next     = compare_b_reg;
        irq_mask_next      = irq_mask_reg;
        pin_oe_next        = pin_oe_reg;
        prescale_left_next = prescale_left_reg;
        counter_next       = counter_reg;
        flags_next         = flags_reg;
        out_a_next         = out_a_reg;
        out_b_next         = out_b_reg;
        state_next         = state_reg;
        cyc_left_next      = cyc_left_reg;
        irq_next           = irq_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cyc_left_next = in_data.cycle_count;
                    irq_next      = 3'd0;
                    state_next    = ST_FIN;
                    case (in_data.opcode)
                        OP_ADVANCE:
                        begin
                            if ((divisor != '0) && (in_data.cycle_count != 8'd0))
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_FORCE_A:
                        begin
                            if (mode_ok)
                            begin
                                out_a_next = apply_action(out_a_reg, out_mode_a_reg,
                                                          pin_oe_reg[0]);
                            end
                        end
                        OP_FORCE_B:
                        begin
                            if (mode_ok)
                            begin
                                out_b_next = apply_action(out_b_reg, out_mode_b_reg,
                                                          pin_oe_reg[1]);
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // one CPU cycle per clock
                cyc_left_next = cyc_left_reg - 8'd1;
                if (prescale_left_reg > 11'd1)
                begin
                    prescale_left_next = prescale_left_reg - 11'd1;
                end
                else
                begin
                    prescale_left_next = divisor;
                    if (mode_ok)
                    begin
                        flags_next = flags_reg | tick_raise;
                        irq_next   = irq_reg | (tick_raise & irq_mask_reg);
                        if ((wave_mode_reg == WM_CTC) && tick_raise[FLAG_A])
                        begin
                            counter_next = 8'd0;
                        end
                        else
                        begin
                            counter_next = tick_inc;
                        end
                        if (tick_raise[FLAG_A])
                        begin
                            out_a_next = apply_action(out_a_reg, out_mode_a_reg,
                                                      pin_oe_reg[0]);
                        end
                        if (tick_raise[FLAG_B])
                        begin
                            out_b_next = apply_action(out_b_reg, out_mode_b_reg,
                                                      pin_oe_reg[1]);
                        end
                    end
                end
                if (cyc_left_reg == 8'd1)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // load result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.count_value  = counter_reg;
                    out_data_next.flag_bits    = flags_reg;
                    out_data_next.pin_a_level  = out_a_reg;
                    out_data_next.pin_b_level  = out_b_reg;
                    out_data_next.irq_overflow = irq_reg[FLAG_OVF];
                    out_data_next.irq_match_a  = irq_reg[FLAG_A];
                    out_data_next.irq_match_b  = irq_reg[FLAG_B];
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLOCK_SELECT:
                begin
                    clock_select_next  = cfg_data[2:0];
                    prescale_left_next = divisor_of(cfg_data[2:0]);
                end
                REG_WAVE_MODE:  wave_mode_next  = cfg_data[2:0];
                REG_OUT_MODE_A: out_mode_a_next = cfg_data[1:0];
                REG_OUT_MODE_B: out_mode_b_next = cfg_data[1:0];
                REG_COMPARE_A:  compare_a_next  = cfg_data;
                REG_COMPARE_B:  compare_b_next  = cfg_data;
                REG_IRQ_MASK:   irq_mask_next   = cfg_data[2:0];
                REG_PIN_OE:     pin_oe_next     = cfg_data[1:0];
                default:        pin_oe_next     = pin_oe_reg;
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_select_reg  <= '0;
            wave_mode_reg     <= '0;
            out_mode_a_reg    <= '0;
            out_mode_b_reg    <= '0;
            compare_a_reg     <= '0;
            compare_b_reg     <= '0;
            irq_mask_reg      <= '0;
            pin_oe_reg        <= '0;
            prescale_left_reg <= '0;
            counter_reg       <= '0;
            flags_reg         <= '0;
            out_a_reg         <= 1'b0;
            out_b_reg         <= 1'b0;
            state_reg         <= ST_IDLE;
            cyc_left_reg      <= '0;
            irq_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            clock_select_reg  <= clock_select_next;
            wave_mode_reg     <= wave_mode_next;
            out_mode_a_reg    <= out_mode_a_next;
            out_mode_b_reg    <= out_mode_b_next;
            compare_a_reg     <= compare_a_next;
            compare_b_reg     <= compare_b_next;
            irq_mask_reg      <= irq_mask_next;
            pin_oe_reg        <= pin_oe_next;
            prescale_left_reg <= prescale_left_next;
            counter_reg       <= counter_next;
            flags_reg         <= flags_next;
            out_a_reg         <= out_a_next;
            out_b_reg         <= out_b_next;
            state_reg         <= state_next;
            cyc_left_reg      <= cyc_left_next;
            irq_reg           <= irq_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // Run state always has cycles left to process
    a_run_has_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cyc_left_reg != 8'd0))
        else $error("run state with no cycles left");

    // Sticky flags never clear
    a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((flags_reg & $past(flags_reg)) == $past(flags_reg)))
        else $error("sticky flag cleared");

    // A stopped prescaler never reaches the run state
    a_run_clock_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (divisor != '0))
        else $error("running with stopped clock");

    // A finished result is presented right after leaving the finish state
    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && (state_next == ST_IDLE) |=> out_valid_reg)
        else $error("result not loaded");
`endif

endmodule
